>>> design/fpm_pkg.sv
// ----------------------------------------------------------------------------
// Frame period monitor package
// Transaction types, register indexes and fixed constants shared by the
// frame period histogram monitor and its divider.
// ----------------------------------------------------------------------------
package fpm_pkg;

   localparam int TIME_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int FIELD_W    = 10;
   localparam int CSR_DATA_W = 16;
   localparam int MIN_PEAK_W = 16;
   localparam int GAP_LIM_W  = 12;
   localparam int REM_W      = 20;

   localparam logic [TIME_W-1:0]     ROUND_NS  = 64'd500000;
   localparam logic [REM_W-1:0]      NS_PER_MS = 20'd1000000;
   localparam logic [COUNT_W-1:0]    COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [MIN_PEAK_W-1:0] MIN_PEAK_RESET  = 16'd100;
   localparam logic [GAP_LIM_W-1:0]  GAP_LIMIT_RESET = 12'd200;

   // one million = 2^6 * 15625; exact reciprocal of 15625 for operands below 2^30
   localparam int PRE_SHIFT   = 6;
   localparam int RECIP_IN_W  = 30;
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 44;
   localparam logic [RECIP_W-1:0] RECIP_15625 = 31'd1125899907;

   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_CLEAR = 1'b1;

   localparam logic CSR_MIN_PEAK_COUNT  = 1'b0;
   localparam logic CSR_EMPTY_GAP_LIMIT = 1'b1;

   typedef struct packed {
      logic              func;
      logic [TIME_W-1:0] event_time;
   } fpm_req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] period_ms;
      logic [FIELD_W-1:0] peak_bin;
      logic [COUNT_W-1:0] peak_count;
      logic               period_valid;
      logic               exceptional;
   } fpm_rsp_type;

endpackage

>>> design/fpm_div.sv
// ----------------------------------------------------------------------------
// Period divider
// Divides a 64-bit nanosecond count by one million: a compare flags quotients
// above QUOT_W bits, a shift by six and a reciprocal multiply by 1/15625 give
// the quotient. The dividend is registered on start; product and done follow it.
// ----------------------------------------------------------------------------
module fpm_div
   import fpm_pkg::*;
#(
   parameter int QUOT_W = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   output logic              done,
   output logic [QUOT_W-1:0] quotient,
   output logic              overflow
);

   localparam int PROD_W = RECIP_IN_W + RECIP_W;
   localparam logic [TIME_W-1:0] OVF_LIMIT = (TIME_W'(1) << QUOT_W) * TIME_W'(NS_PER_MS);

   logic              load_ff,  load_in;
   logic              done_ff,  done_in;
   logic [TIME_W-1:0] dvd_ff,   dvd_in;
   logic [PROD_W-1:0] prod_ff,  prod_in;
   logic              ovf_ff,   ovf_in;

   always_comb begin
      load_in = start;
      done_in = load_ff;
      dvd_in  = start ? dividend : dvd_ff;
      prod_in = prod_ff;
      ovf_in  = ovf_ff;
      if (load_ff) begin
         prod_in = PROD_W'(dvd_ff[PRE_SHIFT +: RECIP_IN_W]) * PROD_W'(RECIP_15625);
         ovf_in  = (dvd_ff >= OVF_LIMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         done_ff <= done_in;
      end
      dvd_ff  <= dvd_in;
      prod_ff <= prod_in;
      ovf_ff  <= ovf_in;
   end

   assign done     = done_ff;
   assign quotient = prod_ff[RECIP_SHIFT +: QUOT_W];
   assign overflow = ovf_ff;

endmodule

>>> design/frame_period_histogram_monitor.sv
// Flow: a measured period passes start, the reciprocal divide, bin read, update and a
// walk of one bin per cycle through the RAM port to rsp_valid, ending sooner when the
// walk stops early; a clear sweeps every bin first, a first event replies directly.
// Handshake: one transaction in flight; req_ready returns when the result is loaded
// into the response register; a result held by rsp_ready stalls it.
// Reset: synchronous; a clearing pass over every bin follows, req_ready low meanwhile.
// ----------------------------------------------------------------------------
// Frame period histogram monitor
// Measures frame periods in ms, counts them in a histogram, walks the bins
// for the peak and flags periods far from it.
// ----------------------------------------------------------------------------
module frame_period_histogram_monitor
   import fpm_pkg::*;
#(
   parameter int NUM_BINS = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fpm_req_type           req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fpm_rsp_type           rsp_payload,
   input  logic                  csr_write_enable,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int BIN_W  = $clog2(NUM_BINS);
   localparam int ADDR_W = BIN_W + 1;
   localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(NUM_BINS - 1);
   localparam logic [ADDR_W-1:0] BIN_END  = ADDR_W'(NUM_BINS);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_CLEAR  = 8'b0000_0010,
      ST_START  = 8'b0000_0100,
      ST_DIVIDE = 8'b0000_1000,
      ST_LOOKUP = 8'b0001_0000,
      ST_UPDATE = 8'b0010_0000,
      ST_WALK   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type             state_ff,     state_in;
   logic [BIN_W-1:0]      clr_addr_ff,  clr_addr_in;
   logic                  clr_reply_ff, clr_reply_in;
   logic                  awaiting_ff,  awaiting_in;
   logic [TIME_W-1:0]     last_time_ff, last_time_in;
   logic [TIME_W-1:0]     diff_ff,      diff_in;
   logic [BIN_W-1:0]      bin_ff,       bin_in;
   logic [MIN_PEAK_W-1:0] min_peak_ff,  min_peak_in;
   logic [GAP_LIM_W-1:0]  gap_limit_ff, gap_limit_in;
   logic [ADDR_W-1:0]     rd_addr_ff,   rd_addr_in;
   logic                  rd_vld_ff,    rd_vld_in;
   logic [BIN_W-1:0]      rd_idx_ff,    rd_idx_in;
   logic [COUNT_W-1:0]    best_ff,      best_in;
   logic [BIN_W-1:0]      peak_ff,      peak_in;
   logic [ADDR_W-1:0]     gap_ff,       gap_in;
   fpm_rsp_type           res_ff,       res_in;
   fpm_rsp_type           rsp_ff,       rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0]    bins_mem [NUM_BINS];
   logic [COUNT_W-1:0]    rdata_ff;
   logic                  mem_we;
   logic [BIN_W-1:0]      mem_waddr;
   logic [COUNT_W-1:0]    mem_wdata;
   logic [BIN_W-1:0]      mem_raddr;

   logic                  div_start;
   logic [TIME_W-1:0]     div_dividend;
   logic                  div_done;
   logic [BIN_W-1:0]      div_quot;
   logic                  div_ovf;

   logic                  bin_nz;
   logic [COUNT_W-1:0]    best_nx;
   logic [BIN_W-1:0]      peak_nx;
   logic [ADDR_W-1:0]     gap_eff;
   logic                  walk_stop;
   logic                  exc;

   fpm_div #(
      .QUOT_W (BIN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_quot),
      .overflow (div_ovf)
   );

   assign div_dividend = diff_ff + ROUND_NS;
   assign req_ready    = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      clr_reply_in = clr_reply_ff;
      awaiting_in  = awaiting_ff;
      last_time_in = last_time_ff;
      diff_in      = diff_ff;
      bin_in       = bin_ff;
      min_peak_in  = min_peak_ff;
      gap_limit_in = gap_limit_ff;
      rd_addr_in   = rd_addr_ff;
      rd_vld_in    = rd_vld_ff;
      rd_idx_in    = rd_idx_ff;
      best_in      = best_ff;
      peak_in      = peak_ff;
      gap_in       = gap_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = bin_ff;
      mem_wdata    = '0;
      mem_raddr    = bin_ff;
      div_start    = 1'b0;

      bin_nz    = (rdata_ff != '0);
      best_nx   = (bin_nz && rdata_ff > best_ff) ? rdata_ff : best_ff;
      peak_nx   = (bin_nz && rdata_ff > best_ff) ? rd_idx_ff : peak_ff;
      gap_eff   = bin_nz ? '0 : gap_ff;
      walk_stop = (ADDR_W'(rd_idx_ff) > gap_eff) &&
                  (32'(gap_eff) > 32'(gap_limit_ff));
      exc       = (best_nx > 32'(min_peak_ff)) &&
                  ((ADDR_W'(bin_ff) >= {peak_nx, 1'b0}) || (bin_ff <= (peak_nx >> 1)));

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_PEAK_COUNT:  min_peak_in  = csr_write_data[MIN_PEAK_W-1:0];
            CSR_EMPTY_GAP_LIMIT: gap_limit_in = csr_write_data[GAP_LIM_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.func == FUNC_CLEAR) begin
                  awaiting_in  = 1'b1;
                  clr_addr_in  = '0;
                  clr_reply_in = 1'b1;
                  state_in     = ST_CLEAR;
               end else if (awaiting_ff) begin
                  awaiting_in  = 1'b0;
                  last_time_in = req_payload.event_time;
                  res_in       = '0;
                  state_in     = ST_FINISH;
               end else begin
                  diff_in      = req_payload.event_time - last_time_ff;
                  last_time_in = req_payload.event_time;
                  state_in     = ST_START;
               end
            end
         end
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_waddr   = clr_addr_ff;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_BIN) begin
               res_in   = '0;
               state_in = clr_reply_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_START: begin
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               bin_in   = (div_ovf || div_quot > LAST_BIN) ? LAST_BIN : div_quot;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_we     = 1'b1;
            mem_wdata  = (rdata_ff == COUNT_MAX) ? rdata_ff : rdata_ff + 1'b1;
            rd_addr_in = '0;
            rd_vld_in  = 1'b0;
            best_in    = '0;
            peak_in    = '0;
            gap_in     = '0;
            state_in   = ST_WALK;
         end
         ST_WALK: begin
            mem_raddr = rd_addr_ff[BIN_W-1:0];
            rd_vld_in = 1'b0;
            if (rd_addr_ff < BIN_END) begin
               rd_vld_in  = 1'b1;
               rd_idx_in  = rd_addr_ff[BIN_W-1:0];
               rd_addr_in = rd_addr_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               best_in = best_nx;
               peak_in = peak_nx;
               gap_in  = gap_eff + 1'b1;
               if (walk_stop || rd_idx_ff == LAST_BIN) begin
                  res_in.period_ms    = FIELD_W'(bin_ff);
                  res_in.peak_bin     = FIELD_W'(peak_nx);
                  res_in.peak_count   = best_nx;
                  res_in.period_valid = 1'b1;
                  res_in.exceptional  = exc;
                  rd_vld_in           = 1'b0;
                  state_in            = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bins_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= bins_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_reply_ff <= 1'b0;
         awaiting_ff  <= 1'b1;
         last_time_ff <= '0;
         min_peak_ff  <= MIN_PEAK_RESET;
         gap_limit_ff <= GAP_LIMIT_RESET;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_reply_ff <= clr_reply_in;
         awaiting_ff  <= awaiting_in;
         last_time_ff <= last_time_in;
         min_peak_ff  <= min_peak_in;
         gap_limit_ff <= gap_limit_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff    <= diff_in;
      bin_ff     <= bin_in;
      rd_addr_ff <= rd_addr_in;
      rd_idx_ff  <= rd_idx_in;
      best_ff    <= best_in;
      peak_ff    <= peak_in;
      gap_ff     <= gap_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR) && !rsp_valid_ff)
      else $error("reset did not start the clearing pass");

   a_clear_sweeps: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_payload.func == FUNC_CLEAR)
      |=> (state_ff == ST_CLEAR) && awaiting_ff)
      else $error("clear transaction did not start a sweep");

   a_period_has_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.period_valid |-> (rsp_ff.peak_count != '0))
      else $error("measured period reported with an empty peak");

   a_no_period_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.period_valid
      |-> !rsp_ff.exceptional && (rsp_ff.peak_count == '0))
      else $error("non-measuring transaction carried peak data");

   a_exc_over_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.exceptional
      |-> rsp_ff.period_valid && (rsp_ff.peak_count > 32'(min_peak_ff)))
      else $error("exceptional flag without a peak above the minimum");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (rd_addr_ff <= BIN_END))
      else $error("walk address ran past the histogram");

endmodule
